// ----- hw/rtl/linear_level_fader_core_assert.svh -----
`ifndef LINEAR_LEVEL_FADER_CORE_ASSERT_SVH
`define LINEAR_LEVEL_FADER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LLF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/llf_pkg.sv -----
package llf_pkg;

	localparam int TIME_BITS = 32;
	localparam int LEVEL_W   = 8;
	localparam int DUR_W     = 16;
	localparam int NUM_W     = LEVEL_W + DUR_W + 1;
	localparam int MAG_W     = NUM_W - 1;
	localparam int PROD_W    = LEVEL_W + DUR_W + 2;
	localparam int SUM_W     = LEVEL_W + 2;
	localparam int CNT_W     = $clog2(MAG_W);

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_FORCE  = 2'd2;

	localparam logic [DUR_W-1:0]   DUR_RESET = 16'd4000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_START,
		ST_DIV,
		ST_CLAMP,
		ST_POST,
		ST_OUT
	} state_t;

endpackage

// ----- hw/rtl/linear_level_fader_core.sv -----
// result follows an accepted item via EVAL and OUT for force, via EVAL, POST and OUT
// for hold or jump to target, via EVAL, START, DIV, CLAMP, POST, OUT if interpolated
// one item in flight: next item taken in the cycle after its result is registered
// interpolation time is set by the 24-step bit-serial divider, one quotient bit a cycle
// async reset: levels and ramp start time cleared, fade duration 4000 ms, no result valid
`include "linear_level_fader_core_assert.svh"

module linear_level_fader_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [31:0]                   now_ms,
	input  logic [llf_pkg::LEVEL_W-1:0]   new_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [llf_pkg::LEVEL_W-1:0]   level,
	output logic [llf_pkg::LEVEL_W-1:0]   target_level,
	output logic                          fade_active,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [llf_pkg::DUR_W-1:0]     cfg_data
);

	llf_pkg::state_t state_q, state_d;

	logic [llf_pkg::DUR_W-1:0] dur_q;
	llf_pkg::level_t           cur_q, cur_d;
	llf_pkg::level_t           start_q, start_d;
	llf_pkg::level_t           tgt_q, tgt_d;
	llf_pkg::time_t            t0_q, t0_d;

	logic [1:0]                cmd_q;
	llf_pkg::time_t            now_q;
	llf_pkg::level_t           lvl_q;

	logic signed [llf_pkg::NUM_W-1:0] num_q, num_d;
	logic                             neg_q;

	logic                      out_valid_q;
	llf_pkg::level_t           level_q;
	llf_pkg::level_t           target_q;
	logic                      fade_active_q;

	logic                      in_accept;
	logic                      out_load;
	logic                      div_start;
	logic                      div_done;
	logic [llf_pkg::MAG_W-1:0] div_mag;
	logic [llf_pkg::MAG_W-1:0] div_quot;

	llf_pkg::time_t                      elapsed;
	logic                                late;
	logic signed [llf_pkg::LEVEL_W:0]    delta;
	logic signed [llf_pkg::DUR_W:0]      el_s;
	logic signed [llf_pkg::PROD_W-1:0]   prod;
	logic signed [llf_pkg::PROD_W-1:0]   half_dur;
	logic signed [llf_pkg::PROD_W-1:0]   sum;
	logic signed [llf_pkg::SUM_W-1:0]    q_s;
	logic signed [llf_pkg::SUM_W-1:0]    scaled;

	assign in_stall  = (state_q != llf_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	llf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (dur_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		elapsed  = now_q - t0_q;
		late     = (dur_q == '0) || (elapsed >= llf_pkg::TIME_BITS'(dur_q));
		delta    = $signed({1'b0, tgt_q}) - $signed({1'b0, start_q});
		el_s     = $signed({1'b0, elapsed[llf_pkg::DUR_W-1:0]});
		prod     = delta * el_s;
		half_dur = $signed(llf_pkg::PROD_W'(dur_q >> 1));
		sum      = prod + half_dur;
		div_mag  = num_q[llf_pkg::NUM_W-1] ? llf_pkg::MAG_W'(-num_q)
			: num_q[llf_pkg::MAG_W-1:0];
		q_s      = neg_q ? -$signed(llf_pkg::SUM_W'(div_quot))
			: $signed(llf_pkg::SUM_W'(div_quot));
		scaled   = $signed({2'b00, start_q}) + q_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		start_d   = start_q;
		tgt_d     = tgt_q;
		t0_d      = t0_q;
		num_d     = num_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			llf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = llf_pkg::ST_EVAL;
				end
			end
			llf_pkg::ST_EVAL: begin
				if (cmd_q == llf_pkg::CMD_FORCE) begin
					cur_d   = lvl_q;
					start_d = lvl_q;
					tgt_d   = lvl_q;
					t0_d    = now_q;
					state_d = llf_pkg::ST_OUT;
				end else if (cur_q == tgt_q) begin
					state_d = llf_pkg::ST_POST;
				end else if (late) begin
					cur_d   = tgt_q;
					start_d = tgt_q;
					state_d = llf_pkg::ST_POST;
				end else begin
					num_d   = sum[llf_pkg::NUM_W-1:0];
					state_d = llf_pkg::ST_START;
				end
			end
			llf_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = llf_pkg::ST_DIV;
			end
			llf_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = llf_pkg::ST_CLAMP;
				end
			end
			llf_pkg::ST_CLAMP: begin
				if (scaled <= 0) begin
					cur_d = '0;
				end else if (scaled >= $signed({2'b00, llf_pkg::LEVEL_MAX})) begin
					cur_d = llf_pkg::LEVEL_MAX;
				end else begin
					cur_d = scaled[llf_pkg::LEVEL_W-1:0];
				end
				state_d = llf_pkg::ST_POST;
			end
			llf_pkg::ST_POST: begin
				if ((cmd_q == llf_pkg::CMD_SET) && (tgt_q != lvl_q)) begin
					start_d = cur_q;
					tgt_d   = lvl_q;
					t0_d    = now_q;
					if (dur_q == '0) begin
						cur_d   = lvl_q;
						start_d = lvl_q;
					end
				end
				state_d = llf_pkg::ST_OUT;
			end
			llf_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = llf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = llf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q       <= llf_pkg::DUR_RESET;
			cur_q       <= '0;
			start_q     <= '0;
			tgt_q       <= '0;
			t0_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dur_q <= cfg_data;
			end
			cur_q   <= cur_d;
			start_q <= start_d;
			tgt_q   <= tgt_d;
			t0_q    <= t0_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= cmd;
			now_q <= llf_pkg::TIME_BITS'(now_ms);
			lvl_q <= new_level;
		end
		num_q <= num_d;
		if (div_start) begin
			neg_q <= num_q[llf_pkg::NUM_W-1];
		end
		if (out_load) begin
			level_q       <= cur_q;
			target_q      <= tgt_q;
			fade_active_q <= (cur_q != tgt_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign level        = level_q;
	assign target_level = target_q;
	assign fade_active  = fade_active_q;

	`LLF_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == llf_pkg::ST_DIV,
		"divider finished outside its wait state")
	`LLF_ASSERT_NEXT(a_idle_holds_levels, (state_q == llf_pkg::ST_IDLE) && !in_accept,
		$stable(cur_q) && $stable(start_q) && $stable(tgt_q) && $stable(t0_q),
		"fade state changed with no item")
	`LLF_ASSERT_IMPL(a_out_active_match, out_valid_q,
		fade_active_q == (level_q != target_q),
		"active flag disagrees with level and target")
	`LLF_ASSERT_NEXT(a_div_start_from_eval, div_start,
		$past(state_q, 2) == llf_pkg::ST_EVAL,
		"divider started without a fresh numerator")

endmodule

// ----- hw/rtl/llf_div.sv -----
module llf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [llf_pkg::MAG_W-1:0] dividend,
	input  logic [llf_pkg::DUR_W-1:0] divisor,
	output logic                      done,
	output logic [llf_pkg::MAG_W-1:0] quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [llf_pkg::CNT_W-1:0]   cnt_q;
	logic [llf_pkg::MAG_W-1:0]   work_q;
	logic [llf_pkg::DUR_W-1:0]   rem_q;
	logic [llf_pkg::DUR_W-1:0]   dvs_q;
	logic [llf_pkg::DUR_W:0]     trial;
	logic [llf_pkg::DUR_W+1:0]   diff;
	logic                        ge;

	// one restoring step per cycle, msb first
	always_comb begin
		trial = {rem_q, work_q[llf_pkg::MAG_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = !diff[llf_pkg::DUR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == llf_pkg::CNT_W'(llf_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[llf_pkg::MAG_W-2:0], ge};
			rem_q  <= ge ? diff[llf_pkg::DUR_W-1:0] : trial[llf_pkg::DUR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule
